/* rtl/core/serial_frame_parser_crc8_core_defines.svh */
// Assertion macros shared by the parser core.
`ifndef SERIAL_FRAME_PARSER_CRC8_CORE_DEFINES_SVH
`define SERIAL_FRAME_PARSER_CRC8_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfp assertion failed");

`endif

/* rtl/core/sfp_pkg.sv */
`timescale 1ns / 1ps
package sfp_pkg;

  localparam int SFP_PAYLOAD_DEPTH = 32;
  localparam int SFP_PADDR_W       = 4;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam logic [7:0]  HEAD_RST = 8'hAA;
  localparam logic [7:0]  TAIL_RST = 8'h55;
  localparam logic [1:0]  MODE_RST = 2'd2;
  localparam logic [15:0] GAP_RST  = 16'd100;

  // Register indexes (byte address 4 * index)
  localparam logic [1:0] REG_HEAD = 2'd0;
  localparam logic [1:0] REG_TAIL = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;
  localparam logic [1:0] REG_GAP  = 2'd3;

  // Check modes
  localparam logic [1:0] CHK_NONE  = 2'd0;
  localparam logic [1:0] CHK_XOR   = 2'd1;
  localparam logic [1:0] CHK_CRC8  = 2'd2;
  localparam logic [1:0] CHK_CRC16 = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_GOOD     = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_BAD_TAIL = 2'd2;
  localparam logic [1:0] STAT_UNSUPP   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_LEN,
    S_PAYLOAD,
    S_CHECK,
    S_TAIL,
    S_EMIT_RD,
    S_EMIT_WR
  } sfp_state_t;

  typedef struct packed {
    logic [7:0]  head;
    logic [7:0]  tail;
    logic [1:0]  mode;
    logic [15:0] gap;
  } sfp_cfg_t;

  typedef struct packed {
    logic cap_arrival;
    logic load_cmd;
    logic load_len;
    logic load_pay;
    logic load_rcv;
    logic restart;
    logic emit_start;
    logic emit_rd;
    logic out_load_status;
    logic out_load_data;
  } sfp_cmd_t;

  typedef struct packed {
    logic timeout;
    logic head_match;
    logic len_zero;
    logic pay_done;
    logic emit_multi;
    logic emit_last;
  } sfp_sts_t;

  // CRC8, polynomial 0x31, MSB first, one byte.
  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_TOP) != 8'h00) begin
        v = (v << 1) ^ CRC_POLY;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

  function automatic logic [7:0] fold_check(input logic [7:0] c, input logic [7:0] b,
                                            input logic [1:0] mode);
    logic [7:0] r;
    case (mode)
      CHK_XOR:  r = c ^ b;
      CHK_CRC8: r = crc8_step(c, b);
      default:  r = c;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/sfp_in_if.sv */
`timescale 1ns / 1ps
interface sfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;

  modport source (output valid, output rx_byte, output now_ms, input ready);
  modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

/* rtl/core/sfp_out_if.sv */
`timescale 1ns / 1ps
interface sfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] command;
  logic [7:0] length_field;
  logic       has_data;
  logic [7:0] payload_byte;
  logic [5:0] payload_pos;
  logic       truncated;
  logic       last;

  modport source (output valid, output status, output command, output length_field,
                  output has_data, output payload_byte, output payload_pos,
                  output truncated, output last, input ready);
  modport sink   (input valid, input status, input command, input length_field,
                  input has_data, input payload_byte, input payload_pos,
                  input truncated, input last, output ready);
endinterface

/* rtl/core/sfp_regs.sv */
`timescale 1ns / 1ps
module sfp_regs import sfp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [SFP_PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output sfp_cfg_t               cfg
);

  sfp_cfg_t   cfg_r;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head <= HEAD_RST;
      cfg_r.tail <= TAIL_RST;
      cfg_r.mode <= MODE_RST;
      cfg_r.gap  <= GAP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HEAD: cfg_r.head <= pwdata[7:0];
        REG_TAIL: cfg_r.tail <= pwdata[7:0];
        REG_MODE: cfg_r.mode <= pwdata[1:0];
        REG_GAP:  cfg_r.gap  <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEAD: prdata = {24'h0, cfg_r.head};
      REG_TAIL: prdata = {24'h0, cfg_r.tail};
      REG_MODE: prdata = {30'h0, cfg_r.mode};
      REG_GAP:  prdata = {16'h0, cfg_r.gap};
      default:  prdata = 32'h0;
    endcase
  end

endmodule

/* rtl/core/sfp_ctrl.sv */
`timescale 1ns / 1ps
module sfp_ctrl import sfp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  sfp_sts_t sts,
  output sfp_cmd_t cmd
);

  sfp_state_t state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       in_rdy;
  logic       acc;
  logic       slot_free;

  assign slot_free = !out_vld_r || out_ready;
  assign acc       = in_valid && in_rdy;
  assign in_ready  = in_rdy;
  assign out_valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Only the tail byte needs a free output slot.
  always_comb begin
    case (state_r)
      S_IDLE, S_CMD, S_LEN, S_PAYLOAD, S_CHECK: in_rdy = 1'b1;
      S_TAIL:                                   in_rdy = slot_free;
      default:                                  in_rdy = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    if (acc && state_r != S_IDLE && sts.timeout) begin
      cmd.restart = 1'b1;
      state_nxt   = S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            cmd.cap_arrival = 1'b1;
            if (sts.head_match) state_nxt = S_CMD;
          end
        end
        S_CMD: begin
          if (acc) begin
            cmd.cap_arrival = 1'b1;
            cmd.load_cmd    = 1'b1;
            state_nxt       = S_LEN;
          end
        end
        S_LEN: begin
          if (acc) begin
            cmd.cap_arrival = 1'b1;
            cmd.load_len    = 1'b1;
            state_nxt       = sts.len_zero ? S_CHECK : S_PAYLOAD;
          end
        end
        S_PAYLOAD: begin
          if (acc) begin
            cmd.cap_arrival = 1'b1;
            cmd.load_pay    = 1'b1;
            if (sts.pay_done) state_nxt = S_CHECK;
          end
        end
        S_CHECK: begin
          if (acc) begin
            cmd.cap_arrival = 1'b1;
            cmd.load_rcv    = 1'b1;
            state_nxt       = S_TAIL;
          end
        end
        S_TAIL: begin
          if (acc) begin
            cmd.cap_arrival = 1'b1;
            cmd.restart     = 1'b1;
            if (sts.emit_multi) begin
              cmd.emit_start = 1'b1;
              state_nxt      = S_EMIT_RD;
            end else begin
              cmd.out_load_status = 1'b1;
              state_nxt           = S_IDLE;
            end
          end
        end
        S_EMIT_RD: begin
          cmd.emit_rd = 1'b1;
          state_nxt   = S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (slot_free) begin
            cmd.out_load_data = 1'b1;
            state_nxt         = sts.emit_last ? S_IDLE : S_EMIT_RD;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_comb begin
    if (cmd.out_load_status || cmd.out_load_data) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

endmodule

/* rtl/core/sfp_dp.sv */
`timescale 1ns / 1ps
module sfp_dp import sfp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = SFP_PAYLOAD_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sfp_cfg_t    cfg,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] now_ms,
  input  sfp_cmd_t    cmd,
  output sfp_sts_t    sts,
  output logic [1:0]  status,
  output logic [7:0]  command,
  output logic [7:0]  length_field,
  output logic        has_data,
  output logic [7:0]  payload_byte,
  output logic [5:0]  payload_pos,
  output logic        truncated,
  output logic        last
);

  localparam int         IDXW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [7:0] DEPTH_B = 8'(PAYLOAD_DEPTH);
  localparam logic [IDXW-1:0] LAST_IDX_MAX = IDXW'(PAYLOAD_DEPTH - 1);

  logic [31:0]     last_arrival_r;
  logic [7:0]      cmd_r, len_r, cnt_r, chk_r, rcv_r;
  logic [7:0]      mem_r [PAYLOAD_DEPTH];
  logic [7:0]      rd_r;
  logic [IDXW-1:0] idx_r, last_idx_r;
  logic [31:0]     elapsed;
  logic [7:0]      cnt_inc;
  logic [7:0]      cmd_base;
  logic [1:0]      tail_st;
  logic            trunc;

  assign elapsed  = now_ms - last_arrival_r;
  assign cnt_inc  = cnt_r + 8'd1;
  assign cmd_base = (cfg.mode == CHK_CRC8) ? CRC_INIT : chk_r;
  assign trunc    = len_r > DEPTH_B;

  always_comb begin
    if (rx_byte != cfg.tail) begin
      tail_st = STAT_BAD_TAIL;
    end else if (cfg.mode == CHK_CRC16) begin
      tail_st = STAT_UNSUPP;
    end else if (cfg.mode != CHK_NONE && rcv_r != chk_r) begin
      tail_st = STAT_MISMATCH;
    end else begin
      tail_st = STAT_GOOD;
    end
  end

  assign sts.timeout    = (cfg.gap != 16'h0) && (elapsed >= {16'h0, cfg.gap});
  assign sts.head_match = rx_byte == cfg.head;
  assign sts.len_zero   = rx_byte == 8'h0;
  assign sts.pay_done   = cnt_inc >= len_r;
  assign sts.emit_multi = (tail_st == STAT_GOOD) && (len_r != 8'h0);
  assign sts.emit_last  = idx_r == last_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_arrival_r <= 32'h0;
      cmd_r          <= 8'h0;
      len_r          <= 8'h0;
      cnt_r          <= 8'h0;
      chk_r          <= 8'h0;
      rcv_r          <= 8'h0;
    end else begin
      if (cmd.cap_arrival) last_arrival_r <= now_ms;
      if (cmd.restart) begin
        cnt_r <= 8'h0;
        chk_r <= 8'h0;
      end
      if (cmd.load_cmd) begin
        cmd_r <= rx_byte;
        chk_r <= fold_check(cmd_base, rx_byte, cfg.mode);
      end
      if (cmd.load_len) begin
        len_r <= rx_byte;
        cnt_r <= 8'h0;
        chk_r <= fold_check(chk_r, rx_byte, cfg.mode);
      end
      if (cmd.load_pay) begin
        cnt_r <= cnt_inc;
        chk_r <= fold_check(chk_r, rx_byte, cfg.mode);
      end
      if (cmd.load_rcv) rcv_r <= rx_byte;
    end
  end

  // Payload store: one write port while parsing, one read port while emitting.
  always_ff @(posedge clk) begin
    if (cmd.load_pay && cnt_r < DEPTH_B) mem_r[cnt_r[IDXW-1:0]] <= rx_byte;
    if (cmd.emit_rd) rd_r <= mem_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      last_idx_r <= '0;
    end else if (cmd.emit_start) begin
      idx_r      <= '0;
      last_idx_r <= trunc ? LAST_IDX_MAX : IDXW'(len_r - 8'd1);
    end else if (cmd.out_load_data) begin
      idx_r <= idx_r + IDXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_status) begin
      status       <= tail_st;
      command      <= cmd_r;
      length_field <= len_r;
      has_data     <= 1'b0;
      payload_byte <= 8'h0;
      payload_pos  <= 6'h0;
      truncated    <= trunc;
      last         <= 1'b1;
    end else if (cmd.out_load_data) begin
      status       <= STAT_GOOD;
      command      <= cmd_r;
      length_field <= len_r;
      has_data     <= 1'b1;
      payload_byte <= rd_r;
      payload_pos  <= 6'(idx_r);
      truncated    <= trunc;
      last         <= sts.emit_last;
    end
  end

endmodule

/* rtl/core/serial_frame_parser_crc8_core.sv */
`timescale 1ns / 1ps
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+--------------------------------------------
// in_ch     | in  | valid / ready      | rx_byte, now_ms
// out_ch    | out | valid / ready      | status, command, length_field, has_data,
//           |     |                    | payload_byte, payload_pos, truncated, last
// config    | in  | psel/penable/pready| paddr, pwdata, prdata (APB-style, 4 regs)
//
// A byte transfer is taken every cycle while parsing; the controller FSM sets the pace.
// The tail byte of a good frame with stored payload starts an emit pass that, for each
// stored byte, reads the store and then loads the output register; in_ch is held off
// for the whole pass.
// A tail byte waits only while the output register is full and not being drained.
// rst_n is synchronous, active low; the payload store is not cleared and needs no pass.
module serial_frame_parser_crc8_core import sfp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = SFP_PAYLOAD_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  sfp_in_if.sink                 in_ch,
  sfp_out_if.source              out_ch,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [SFP_PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

`include "serial_frame_parser_crc8_core_defines.svh"

  sfp_cfg_t cfg;
  sfp_cmd_t cmd;
  sfp_sts_t sts;

  // Configuration registers: head, tail, check mode, gap limit.
  sfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parse phase sequencing, emit pass and output valid.
  sfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Held fields, running check, timeout compare, payload store, output register.
  sfp_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .rx_byte      (in_ch.rx_byte),
    .now_ms       (in_ch.now_ms),
    .cmd          (cmd),
    .sts          (sts),
    .status       (out_ch.status),
    .command      (out_ch.command),
    .length_field (out_ch.length_field),
    .has_data     (out_ch.has_data),
    .payload_byte (out_ch.payload_byte),
    .payload_pos  (out_ch.payload_pos),
    .truncated    (out_ch.truncated),
    .last         (out_ch.last)
  );

  // Never overwrite a result that has not been transferred.
  `SFP_ASSERT_NOW(a_no_overwrite, cmd.out_load_status || cmd.out_load_data, !out_ch.valid || out_ch.ready)
  // Hold off input while a store read is in flight.
  `SFP_ASSERT_NOW(a_no_input_in_emit, cmd.emit_rd, !in_ch.ready)
  // A store read is always followed by its output slot cycle, not another read.
  `SFP_ASSERT_NEXT(a_read_then_load, cmd.emit_rd, !cmd.emit_rd)

endmodule
